FILE: rtl/sdf_pkg.sv
// ----------------------------------------------------------------------------
// Sender duplicate filter package
// Shared word types and default sizes for the sender duplicate filter.
// ----------------------------------------------------------------------------
`default_nettype none

package sdf_pkg;

   localparam int HISTORY_DEPTH_DEF = 8;
   localparam int ADDR_W            = 16;
   localparam int SEQ_W             = 8;
   localparam int TYPE_W            = 8;

   typedef struct packed {
      logic [ADDR_W-1:0] sender_addr;
      logic [SEQ_W-1:0]  seq_number;
      logic [TYPE_W-1:0] packet_type;
   } req_type;

   typedef struct packed {
      logic is_duplicate;
      logic accepted;
      logic new_sender;
      logic evicted_oldest;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [SEQ_W-1:0]  seq;
   } entry_type;

endpackage

`default_nettype wire

FILE: rtl/sender_duplicate_filter_unit.sv
// ----------------------------------------------------------------------------
// Sender duplicate filter
// Flags repeated packets per sender and keeps a FIFO-replaced sender table.
// ----------------------------------------------------------------------------
// A packet word is taken at a clock edge where start is high and busy is low.
// The block then scans the sender table, one entry per cycle through the read
// port of the table memory, and stops at the first entry whose address
// matches. It updates or inserts the entry and presents one result word on
// rsp_word with rsp_strobe high for exactly one cycle. Busy is low in the
// strobe cycle, so the next word may be started there. The receiver cannot
// stall the result.
// The accepted type register is written through the csr channel, which is
// always ready; write it only while busy is low.
// Reset clears the fill count, the replacement pointer, the type register and
// all control state. Table entries beyond the fill count are never read, so
// the table memory needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sender_duplicate_filter_unit
   import sdf_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire req_type           req_word,
   output logic                   rsp_strobe,
   output rsp_type                rsp_word,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [TYPE_W-1:0] csr_data
);

   localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_WRITE = 2'd2;

   logic [1:0]        state_ff, state_in;
   req_type           req_ff, req_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic              hit_ff, hit_in;
   logic              dup_ff, dup_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [IDX_W-1:0]  oldest_ff, oldest_in;
   logic [TYPE_W-1:0] acc_type_ff, acc_type_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_word_ff, rsp_word_in;

   logic              rd_en;
   logic [IDX_W-1:0]  rd_idx;
   entry_type         rd_data;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_idx;
   entry_type         wr_data;
   logic              table_full;

   sdf_table #(
      .DEPTH (HISTORY_DEPTH),
      .IDX_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_idx  (rd_idx),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_data)
   );

   assign rd_idx     = scan_ff[IDX_W-1:0];
   assign table_full = (used_ff == CNT_W'(HISTORY_DEPTH));

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      scan_in       = scan_ff;
      pend_in       = pend_ff;
      cmp_idx_in    = cmp_idx_ff;
      hit_in        = hit_ff;
      dup_in        = dup_ff;
      hit_idx_in    = hit_idx_ff;
      used_in       = used_ff;
      oldest_in     = oldest_ff;
      acc_type_in   = acc_type_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_idx        = hit_idx_ff;
      wr_data.addr  = req_ff.sender_addr;
      wr_data.seq   = req_ff.seq_number;

      if (csr_valid && csr_ready) begin
         acc_type_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_word;
               scan_in  = '0;
               pend_in  = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (pend_ff && (rd_data.addr == req_ff.sender_addr)) begin
               hit_in     = 1'b1;
               dup_in     = (rd_data.seq == req_ff.seq_number);
               hit_idx_in = cmp_idx_ff;
               state_in   = S_WRITE;
            end else if (scan_ff < used_ff) begin
               rd_en      = 1'b1;
               pend_in    = 1'b1;
               cmp_idx_in = scan_ff[IDX_W-1:0];
               scan_in    = scan_ff + CNT_W'(1);
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               hit_in   = 1'b0;
               dup_in   = 1'b0;
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            rsp_word_in.is_duplicate   = hit_ff && dup_ff;
            rsp_word_in.accepted       = !(hit_ff && dup_ff) &&
                                         (req_ff.packet_type == acc_type_ff);
            rsp_word_in.new_sender     = !hit_ff;
            rsp_word_in.evicted_oldest = !hit_ff && table_full;
            if (hit_ff) begin
               wr_en = !dup_ff;
            end else if (table_full) begin
               wr_en  = 1'b1;
               wr_idx = oldest_ff;
               if (oldest_ff == IDX_W'(HISTORY_DEPTH - 1)) begin
                  oldest_in = '0;
               end else begin
                  oldest_in = oldest_ff + IDX_W'(1);
               end
            end else begin
               wr_en   = 1'b1;
               wr_idx  = used_ff[IDX_W-1:0];
               used_in = used_ff + CNT_W'(1);
            end
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_ff       <= 1'b0;
         used_ff       <= '0;
         oldest_ff     <= '0;
         acc_type_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_ff       <= pend_in;
         used_ff       <= used_in;
         oldest_ff     <= oldest_in;
         acc_type_ff   <= acc_type_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      scan_ff     <= scan_in;
      cmp_idx_ff  <= cmp_idx_in;
      hit_ff      <= hit_in;
      dup_ff      <= dup_in;
      hit_idx_ff  <= hit_idx_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule

`default_nettype wire

FILE: rtl/sdf_table.sv
// ----------------------------------------------------------------------------
// Sender table memory
// Synchronous memory of sender entries with one read and one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_table
   import sdf_pkg::*;
#(
   parameter int DEPTH = HISTORY_DEPTH_DEF,
   parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] rd_idx,
   output entry_type             rd_data,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_idx,
   input  wire entry_type        wr_data
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/sdf_checker.sv
// ----------------------------------------------------------------------------
// Sender duplicate filter checker
// Port-level checks on the sender duplicate filter, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_checker
   import sdf_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_strobe,
   input wire rsp_type rsp_word
);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_strobe))
      else $error("Block is not idle after reset.");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("Accepted word did not make the block busy.");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("Result strobe held for more than one cycle.");

   a_dup_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.is_duplicate) |->
         (!rsp_word.accepted && !rsp_word.new_sender))
      else $error("Duplicate word reported as accepted or new.");

   a_evict_new: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.evicted_oldest) |-> rsp_word.new_sender)
      else $error("Eviction reported without a new sender.");

endmodule

bind sender_duplicate_filter_unit sdf_checker u_sdf_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word)
);

`default_nettype wire

FILE: sim/sender_duplicate_filter_unit_tb.sv
// ----------------------------------------------------------------------------
// Sender duplicate filter testbench
// Drives packet words with random start gaps (none in the last phase) and
// checks every result word against a local model of the sender table with
// FIFO replacement, across several settings of the accepted type register.
// ----------------------------------------------------------------------------
module sender_duplicate_filter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sdf_pkg::*;

   localparam int DEPTH       = HISTORY_DEPTH_DEF;
   localparam int POOL_SIZE   = 11;
   localparam int PHASE_ITEMS = 386;
   localparam int STALL_LIMIT = 2000;
   localparam int PRINT_LIMIT = 30;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   req_type           req_word = '0;
   logic              rsp_strobe;
   rsp_type           rsp_word;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [TYPE_W-1:0] csr_data = '0;

   req_type           pending_packets[$];
   rsp_type           expected_verdicts[$];

   logic [ADDR_W-1:0] known_addr[DEPTH];
   logic [SEQ_W-1:0]  known_seq[DEPTH];
   logic              known_valid[DEPTH];
   int                fill_count = 0;
   int                replace_slot = 0;
   logic [TYPE_W-1:0] wanted_type = '0;

   logic [ADDR_W-1:0] addr_pool[POOL_SIZE];

   bit word_taken = 1'b0;
   bit csr_taken = 1'b0;
   bit gaps_on = 1'b1;
   int idle_left = 0;
   int quiet_cycles = 0;
   int mismatch_count = 0;
   int item_count = 0;
   int result_count = 0;
   int dup_count = 0;
   int fresh_count = 0;
   int evict_count = 0;
   int accept_count = 0;
   int csr_write_count = 0;

   sender_duplicate_filter_unit #(
      .HISTORY_DEPTH(DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t MISMATCH: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic got, input logic want);
      if (got !== want)
         report_mismatch($sformatf("result %0d field %s: got %b, expected %b",
                                   result_count, name, got, want));
   endtask

   // Looks up the sender, updates the table the way the block must, and
   // queues the verdict for the word.
   task automatic classify_packet(input req_type w);
      rsp_type r;
      int      hit;
      int      slot;
      int      i;
      r = '0;
      hit = -1;
      for (i = 0; i < DEPTH; i++) begin
         if (hit < 0 && known_valid[i] && known_addr[i] == w.sender_addr)
            hit = i;
      end
      if (hit >= 0) begin
         if (known_seq[hit] == w.seq_number)
            r.is_duplicate = 1'b1;
         else
            known_seq[hit] = w.seq_number;
      end else begin
         if (fill_count < DEPTH) begin
            slot = fill_count;
            fill_count++;
         end else begin
            slot = replace_slot;
            replace_slot = (replace_slot + 1) % DEPTH;
            r.evicted_oldest = 1'b1;
         end
         known_addr[slot] = w.sender_addr;
         known_seq[slot] = w.seq_number;
         known_valid[slot] = 1'b1;
         r.new_sender = 1'b1;
      end
      r.accepted = !r.is_duplicate && w.packet_type == wanted_type;
      dup_count += int'(r.is_duplicate);
      fresh_count += int'(r.new_sender);
      evict_count += int'(r.evicted_oldest);
      accept_count += int'(r.accepted);
      expected_verdicts.push_back(r);
   endtask

   task automatic queue_packet(input logic [ADDR_W-1:0] addr, input logic [SEQ_W-1:0] seq,
                               input logic [TYPE_W-1:0] ptype);
      req_type w;
      w.sender_addr = addr;
      w.seq_number = seq;
      w.packet_type = ptype;
      pending_packets.push_back(w);
   endtask

   // Most packets come from a small set of senders so that repeats, updates
   // and evictions are all frequent; the rest are arbitrary.
   task automatic queue_random_packets(input int count, input logic [TYPE_W-1:0] cfg);
      logic [ADDR_W-1:0] addr;
      logic [SEQ_W-1:0]  seq;
      logic [TYPE_W-1:0] ptype;
      int                i;
      for (i = 0; i < POOL_SIZE; i++)
         addr_pool[i] = ADDR_W'($urandom);
      for (i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) < 8)
            addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
         else
            addr = ADDR_W'($urandom);
         if ($urandom_range(0, 1) == 1)
            seq = SEQ_W'($urandom_range(0, 2));
         else
            seq = SEQ_W'($urandom);
         if ($urandom_range(0, 1) == 1)
            ptype = cfg;
         else
            ptype = TYPE_W'($urandom);
         queue_packet(addr, seq, ptype);
      end
   endtask

   task automatic wait_until_drained();
      while (pending_packets.size() > 0 || start || expected_verdicts.size() > 0)
         @(negedge clock);
      repeat (DEPTH + 3) @(negedge clock);
   endtask

   task automatic write_accepted_type(input logic [TYPE_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do
         @(negedge clock);
      while (!csr_taken);
      csr_taken = 1'b0;
      csr_valid <= 1'b0;
   endtask

   always @(negedge clock) begin
      if (!start || word_taken) begin
         word_taken = 1'b0;
         if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            idle_left = $urandom_range(0, 14);
            start <= 1'b0;
         end else if (pending_packets.size() > 0) begin
            start <= 1'b1;
            req_word <= pending_packets.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      bit      progress;
      progress = 1'b0;
      if (!reset) begin
         if (rsp_strobe) begin
            progress = 1'b1;
            result_count++;
            if (expected_verdicts.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing expected",
                                         result_count));
            end else begin
               want = expected_verdicts.pop_front();
               check_field("is_duplicate", rsp_word.is_duplicate, want.is_duplicate);
               check_field("accepted", rsp_word.accepted, want.accepted);
               check_field("new_sender", rsp_word.new_sender, want.new_sender);
               check_field("evicted_oldest", rsp_word.evicted_oldest, want.evicted_oldest);
            end
         end
         if (start && !busy) begin
            progress = 1'b1;
            item_count++;
            classify_packet(req_word);
            word_taken = 1'b1;
         end
         if (csr_valid && csr_ready) begin
            progress = 1'b1;
            wanted_type = csr_data;
            csr_write_count++;
            csr_taken = 1'b1;
         end
      end
      if (progress)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t timeout after %0d quiet cycles", $realtime, quiet_cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      logic [TYPE_W-1:0] cfg;
      int                a;
      int                p;
      for (a = 0; a < DEPTH; a++)
         known_valid[a] = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // The type register still holds its reset value of zero here.
      queue_packet(16'h0000, 8'h00, 8'h00);
      queue_packet(16'h0000, 8'h00, 8'h00);
      queue_packet(16'h0000, 8'hFF, 8'hFF);
      queue_packet(16'hFFFF, 8'hFF, 8'h00);
      queue_packet(16'hFFFF, 8'hFF, 8'h00);
      queue_packet(16'hFFFF, 8'h00, 8'h00);
      for (a = 1; a <= DEPTH - 2; a++)
         queue_packet(a[ADDR_W-1:0], a[SEQ_W-1:0], 8'hFF);
      queue_packet(16'hAAAA, 8'h55, 8'hAA);
      queue_packet(16'h0000, 8'h00, 8'h00);
      queue_packet(16'h0003, 8'h07, 8'h00);
      queue_packet(16'h5555, 8'hAA, 8'h55);
      queue_packet(16'h0000, 8'h00, 8'h00);
      wait_until_drained();

      write_accepted_type(8'hFF);
      queue_packet(16'h1234, 8'h01, 8'hFF);
      queue_packet(16'h1234, 8'h01, 8'hFF);
      queue_packet(16'h0002, 8'h00, 8'hFF);
      wait_until_drained();

      for (p = 0; p < 5; p++) begin
         case (p)
            0: cfg = 8'h00;
            1: cfg = 8'hFF;
            default: cfg = TYPE_W'($urandom);
         endcase
         write_accepted_type(cfg);
         if (p == 4)
            gaps_on = 1'b0;
         queue_random_packets(PHASE_ITEMS, cfg);
         wait_until_drained();
      end

      $display("Covered %0d packet words and %0d results over %0d type settings.",
               item_count, result_count, csr_write_count + 1);
      $display("Saw %0d repeats, %0d new senders, %0d evictions and %0d accepted packets.",
               dup_count, fresh_count, evict_count, accept_count);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches found", mismatch_count);
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
